@@ rtl/rmq_pkg.sv @@
// Shared constants for the rotation matrix to quaternion unit.
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  // Guard bits carried below the root.
  localparam int EXT = 2;

  // Codes reported on case_taken.
  localparam logic [1:0] CASE_TRACE = 2'd0;
  localparam logic [1:0] CASE_X     = 2'd1;
  localparam logic [1:0] CASE_Y     = 2'd2;
  localparam logic [1:0] CASE_Z     = 2'd3;

endpackage

@@ rtl/rmq_div_lane.sv @@
// Pipelined restoring divider for one off-diagonal quaternion component.
module rmq_div_lane import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int ROOT_W     = 18
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [DATA_WIDTH:0]          mag,
  input  logic                         neg,
  input  logic [ROOT_W-1:0]            root,
  output logic signed [DATA_WIDTH-1:0] q
);

  localparam int SH   = FRAC_BITS + EXT - 1;
  localparam int QW   = DATA_WIDTH + 1;
  localparam int NW   = QW + SH;
  localparam int CMPW = (SH > ROOT_W) ? SH : ROOT_W;

  logic [NW-1:0]     num;
  logic [SH-1:0]     num_hi;
  logic              ovf_c;

  logic [ROOT_W-1:0] st_rem [QW+1];
  logic [QW-1:0]     st_q   [QW+1];
  logic [QW-1:0]     st_lo  [QW+1];
  logic [ROOT_W-1:0] st_r   [QW+1];
  logic              st_neg [QW+1];
  logic              st_ovf [QW+1];

  assign num    = NW'(mag) << SH;
  assign num_hi = num[NW-1:QW];
  // The quotient would not fit in QW bits, so the result saturates.
  assign ovf_c  = CMPW'(num_hi) >= CMPW'(root);

  always_ff @(posedge clk) begin
    if (en) begin
      st_ovf[0] <= ovf_c;
      st_rem[0] <= ovf_c ? '0 : ROOT_W'(num_hi);
      st_q[0]   <= '0;
      st_lo[0]  <= num[QW-1:0];
      st_r[0]   <= root;
      st_neg[0] <= neg;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [ROOT_W:0] trial;
    logic            ge;

    assign trial = {st_rem[j-1], st_lo[j-1][QW-1]};
    assign ge    = trial >= {1'b0, st_r[j-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[j] <= ge ? ROOT_W'(trial - {1'b0, st_r[j-1]}) : ROOT_W'(trial);
        st_q[j]   <= {st_q[j-1][QW-2:0], ge};
        st_lo[j]  <= st_lo[j-1] << 1;
        st_r[j]   <= st_r[j-1];
        st_neg[j] <= st_neg[j-1];
        st_ovf[j] <= st_ovf[j-1];
      end
    end
  end

  logic          rup;
  logic [QW:0]   qr;
  logic [QW:0]   lim;
  logic [QW:0]   qs;
  logic [QW:0]   qpos;

  always_comb begin
    // Round half away from zero on the magnitude.
    rup  = {st_rem[QW], 1'b0} >= {1'b0, st_r[QW]};
    qr   = (QW+1)'(st_q[QW]) + (QW+1)'(rup);
    lim  = (QW+1)'(1) << (DATA_WIDTH - 1);
    qs   = (st_ovf[QW] || (qr > lim)) ? lim : qr;
    qpos = (qs == lim) ? lim - (QW+1)'(1) : qs;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= st_neg[QW] ? DATA_WIDTH'(-qs) : DATA_WIDTH'(qpos);
    end
  end

endmodule

@@ rtl/rotation_matrix_to_quaternion_unit.sv @@
// Rotation matrix to quaternion conversion, fully pipelined.
//
// One 3x3 matrix enters per transaction on the input channel (in_valid,
// in_stall); one quaternion leaves per transaction on the output channel
// (out_valid, out_stall), together with the case that was chosen and a
// degenerate flag. A new matrix may be offered in every cycle.
// The square root resolves one bit of the RW-bit root per stage, where RW is
// half of (AW - 1 + FRAC_BITS + 4) rounded up with AW the width of the root
// argument A; it is followed by the three dividers, one quotient bit per
// stage. One transaction is accepted per cycle while in_stall is low.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m01,
  input  logic signed [DATA_WIDTH-1:0] m02,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m11,
  input  logic signed [DATA_WIDTH-1:0] m12,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] qw,
  output logic signed [DATA_WIDTH-1:0] qx,
  output logic signed [DATA_WIDTH-1:0] qy,
  output logic signed [DATA_WIDTH-1:0] qz,
  output logic [1:0]                   case_taken,
  output logic                         degenerate
);

  localparam int AW  = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
  localparam int XW0 = AW - 1 + FRAC_BITS + 2 * EXT;
  localparam int XW  = XW0 + (XW0 % 2);
  localparam int RW  = XW / 2;
  localparam int MW  = RW + 1;
  localparam int CW  = (MW > DATA_WIDTH) ? MW : DATA_WIDTH;
  localparam int DW1 = DATA_WIDTH + 1;
  localparam int QW  = DATA_WIDTH + 1;
  localparam int LL  = QW + 2;

  typedef struct packed {
    logic [1:0]              sel;
    logic                    deg;
    logic [2:0]              neg;
    logic [2:0][DW1-1:0]     mag;
  } rside_t;

  typedef struct packed {
    logic [1:0]            sel;
    logic                  deg;
    logic [DATA_WIDTH-1:0] main;
  } lside_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Case choice, root argument and numerators.
  logic signed [AW-1:0]  e00, e11, e22, tr, one_c, a_c;
  logic [1:0]            sel_c;
  logic signed [DW1-1:0] d_c [3];
  rside_t                sb_c;
  logic                  deg_c;
  logic [XW-1:0]         x_c;

  assign e00   = AW'(m00);
  assign e11   = AW'(m11);
  assign e22   = AW'(m22);
  assign tr    = e00 + e11 + e22;
  assign one_c = AW'(1) << FRAC_BITS;

  always_comb begin
    priority if (tr > 0) begin
      sel_c  = CASE_TRACE;
      a_c    = one_c + tr;
      d_c[0] = DW1'(m21) - DW1'(m12);
      d_c[1] = DW1'(m02) - DW1'(m20);
      d_c[2] = DW1'(m10) - DW1'(m01);
    end else if (m00 > m11 && m00 > m22) begin
      sel_c  = CASE_X;
      a_c    = one_c + e00 - e11 - e22;
      d_c[0] = DW1'(m21) - DW1'(m12);
      d_c[1] = DW1'(m01) + DW1'(m10);
      d_c[2] = DW1'(m02) + DW1'(m20);
    end else if (m11 > m22) begin
      sel_c  = CASE_Y;
      a_c    = one_c + e11 - e00 - e22;
      d_c[0] = DW1'(m02) - DW1'(m20);
      d_c[1] = DW1'(m01) + DW1'(m10);
      d_c[2] = DW1'(m12) + DW1'(m21);
    end else begin
      sel_c  = CASE_Z;
      a_c    = one_c + e22 - e00 - e11;
      d_c[0] = DW1'(m10) - DW1'(m01);
      d_c[1] = DW1'(m02) + DW1'(m20);
      d_c[2] = DW1'(m12) + DW1'(m21);
    end
    deg_c  = a_c <= 0;
    x_c    = deg_c ? '0 : XW'(a_c[AW-2:0]) << (FRAC_BITS + 2 * EXT);
    sb_c.sel = sel_c;
    sb_c.deg = deg_c;
    for (int i = 0; i < 3; i++) begin
      sb_c.neg[i] = d_c[i][DW1-1];
      sb_c.mag[i] = d_c[i][DW1-1] ? DW1'(-d_c[i]) : DW1'(d_c[i]);
    end
  end

  logic          v0;
  logic [XW-1:0] s0_x;
  rside_t        s0_sb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x  <= x_c;
      s0_sb <= sb_c;
    end
  end

  // Square root, one result bit per stage.
  logic [RW+1:0] rt_rem  [RW];
  logic [RW-1:0] rt_root [RW];
  logic [XW-1:0] rt_x    [RW];
  rside_t        rt_sb   [RW];
  logic          rt_v    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RW+1:0] rem_i;
    logic [RW-1:0] root_i;
    logic [XW-1:0] x_i;
    rside_t        sb_i;
    logic          v_i;
    logic [RW+3:0] rsh, trial;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign x_i    = s0_x;
      assign sb_i   = s0_sb;
      assign v_i    = v0;
    end else begin : g_next
      assign rem_i  = rt_rem[k-1];
      assign root_i = rt_root[k-1];
      assign x_i    = rt_x[k-1];
      assign sb_i   = rt_sb[k-1];
      assign v_i    = rt_v[k-1];
    end

    assign rsh   = {rem_i, x_i[XW-1 -: 2]};
    assign trial = (RW+4)'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[k] <= 1'b0;
      end else if (en) begin
        rt_v[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rsh >= trial) begin
          rt_rem[k]  <= (RW+2)'(rsh - trial);
          rt_root[k] <= {root_i[RW-2:0], 1'b1};
        end else begin
          rt_rem[k]  <= (RW+2)'(rsh);
          rt_root[k] <= {root_i[RW-2:0], 1'b0};
        end
        rt_x[k]  <= x_i << 2;
        rt_sb[k] <= sb_i;
      end
    end
  end

  logic [RW-1:0]         r;
  rside_t                rsb;
  logic [MW-1:0]         msum;
  logic [CW-1:0]         mlim;
  logic [DATA_WIDTH-1:0] main_c;

  assign r    = rt_root[RW-1];
  assign rsb  = rt_sb[RW-1];
  // S/4 rounded half up, held below the positive limit.
  assign msum = (MW'(r) + (MW'(1) << EXT)) >> (EXT + 1);
  assign mlim = (CW'(1) << (DATA_WIDTH - 1)) - CW'(1);
  assign main_c = (CW'(msum) > mlim) ? DATA_WIDTH'(mlim) : DATA_WIDTH'(msum);

  logic signed [DATA_WIDTH-1:0] lq [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    rmq_div_lane #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS),
      .ROOT_W    (RW)
    ) u_lane (
      .clk (clk),
      .en  (en),
      .mag (rsb.mag[i]),
      .neg (rsb.neg[i]),
      .root(r),
      .q   (lq[i])
    );
  end

  // Side information delayed to match the dividers.
  lside_t ls   [LL];
  logic   ls_v [LL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LL; j++) ls_v[j] <= 1'b0;
    end else if (en) begin
      ls_v[0] <= rt_v[RW-1];
      for (int j = 1; j < LL; j++) ls_v[j] <= ls_v[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ls[0] <= '{sel: rsb.sel, deg: rsb.deg, main: main_c};
      for (int j = 1; j < LL; j++) ls[j] <= ls[j-1];
    end
  end

  lside_t                fin;
  logic [DATA_WIDTH-1:0] w_c, x_o, y_o, z_o;

  assign fin = ls[LL-1];

  always_comb begin
    unique case (fin.sel)
      CASE_TRACE: begin
        w_c = fin.main; x_o = lq[0]; y_o = lq[1]; z_o = lq[2];
      end
      CASE_X: begin
        w_c = lq[0]; x_o = fin.main; y_o = lq[1]; z_o = lq[2];
      end
      CASE_Y: begin
        w_c = lq[0]; x_o = lq[1]; y_o = fin.main; z_o = lq[2];
      end
      default: begin
        w_c = lq[0]; x_o = lq[1]; y_o = lq[2]; z_o = fin.main;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ls_v[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw         <= fin.deg ? '0 : w_c;
      qx         <= fin.deg ? '0 : x_o;
      qy         <= fin.deg ? '0 : y_o;
      qz         <= fin.deg ? '0 : z_o;
      case_taken <= fin.sel;
      degenerate <= fin.deg;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> qw == '0 && qx == '0 && qy == '0 && qz == '0)
    else $error("degenerate result with nonzero quaternion");

  a_trace_w: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && case_taken == CASE_TRACE |-> !qw[DATA_WIDTH-1])
    else $error("scalar part negative in the trace case");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

@@ verif/tb.sv @@
// Testbench for the rotation matrix to quaternion unit: random and directed matrices, scoreboard.
module tb;
  import rmq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [DW-1:0] elem_t;
  typedef struct {
    elem_t w, x, y, z;
    logic [1:0] sel;
    logic degen;
  } quat_t;

  int error_count = 0;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    error_count++;
  endtask

  // floor(sqrt(x * 16)), bit by bit
  function automatic longint unsigned isqrt_guard(input longint unsigned x);
    longint unsigned rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 31 + EXT; i >= 0; i--) begin
      pair = (i >= EXT) ? ((x >> (2 * (i - EXT))) & 3) : 0;
      rem = (rem << 2) | pair;
      root = root << 1;
      trial = (root << 1) | 1;
      if (rem >= trial) begin
        rem -= trial;
        root |= 1;
      end
    end
    return root;
  endfunction

  function automatic elem_t clamp(input longint v);
    longint hi, lo;
    hi = (longint'(1) << (DW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return elem_t'(v);
  endfunction

  function automatic elem_t scaled_ratio(input longint d, input longint unsigned r);
    logic neg;
    longint unsigned mag, num, q, rm;
    neg = d < 0;
    mag = neg ? longint'(-d) : longint'(d);
    num = mag << (FB + EXT - 1);
    q = num / r;
    rm = num % r;
    if (rm * 2 >= r) q++;
    if (q > (longint'(1) << (DW - 1))) q = longint'(1) << (DW - 1);
    return clamp(neg ? -longint'(q) : longint'(q));
  endfunction

  function automatic quat_t quat_of(input elem_t m[9]);
    quat_t res;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, a;
    longint n[4];
    longint unsigned r, mainv;
    a00 = m[0]; a01 = m[1]; a02 = m[2];
    a10 = m[3]; a11 = m[4]; a12 = m[5];
    a20 = m[6]; a21 = m[7]; a22 = m[8];
    n = '{0, 0, 0, 0};
    if (a00 + a11 + a22 > 0) begin
      res.sel = CASE_TRACE;
      a = (1 << FB) + a00 + a11 + a22;
      n[1] = a21 - a12; n[2] = a02 - a20; n[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      res.sel = CASE_X;
      a = (1 << FB) + a00 - a11 - a22;
      n[0] = a21 - a12; n[2] = a01 + a10; n[3] = a02 + a20;
    end else if (a11 > a22) begin
      res.sel = CASE_Y;
      a = (1 << FB) + a11 - a00 - a22;
      n[0] = a02 - a20; n[1] = a01 + a10; n[3] = a12 + a21;
    end else begin
      res.sel = CASE_Z;
      a = (1 << FB) + a22 - a00 - a11;
      n[0] = a10 - a01; n[1] = a02 + a20; n[2] = a12 + a21;
    end
    if (a <= 0) begin
      res.w = 0; res.x = 0; res.y = 0; res.z = 0;
      res.degen = 1;
      return res;
    end
    r = isqrt_guard(longint'(a) << FB);
    mainv = (r + (1 << EXT)) >> (EXT + 1);
    if (mainv > (longint'(1) << (DW - 1)) - 1) mainv = (longint'(1) << (DW - 1)) - 1;
    res.w = (res.sel == CASE_TRACE) ? elem_t'(mainv) : scaled_ratio(n[0], r);
    res.x = (res.sel == CASE_X) ? elem_t'(mainv) : scaled_ratio(n[1], r);
    res.y = (res.sel == CASE_Y) ? elem_t'(mainv) : scaled_ratio(n[2], r);
    res.z = (res.sel == CASE_Z) ? elem_t'(mainv) : scaled_ratio(n[3], r);
    res.degen = 0;
    return res;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];

    function void note_matrix(input elem_t m[9]);
      pending.push_back(quat_of(m));
    endfunction

    task check_quat(input quat_t got);
      quat_t e;
      if (pending.size() == 0) begin
        report("result with no matrix outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.w !== e.w) report($sformatf("qw %0d exp %0d", got.w, e.w));
      if (got.x !== e.x) report($sformatf("qx %0d exp %0d", got.x, e.x));
      if (got.y !== e.y) report($sformatf("qy %0d exp %0d", got.y, e.y));
      if (got.z !== e.z) report($sformatf("qz %0d exp %0d", got.z, e.z));
      if (got.sel !== e.sel) report($sformatf("case %0d exp %0d", got.sel, e.sel));
      if (got.degen !== e.degen)
        report($sformatf("degenerate %0b exp %0b", got.degen, e.degen));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  elem_t m00 = 0, m01 = 0, m02 = 0, m10 = 0, m11 = 0, m12 = 0, m20 = 0, m21 = 0, m22 = 0;
  logic out_valid;
  logic out_stall = 0;
  elem_t qw, qx, qy, qz;
  logic [1:0] case_taken;
  logic degenerate;

  rotation_matrix_to_quaternion_unit dut (.*);

  initial forever #1 clk = ~clk;

  quat_scoreboard sb = new();
  logic feeding_done = 0;
  logic long_hold = 0;
  logic hold_done = 0;
  int cycles = 0;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_matrix(input elem_t m[9]);
    m00 <= m[0]; m01 <= m[1]; m02 <= m[2];
    m10 <= m[3]; m11 <= m[4]; m12 <= m[5];
    m20 <= m[6]; m21 <= m[7]; m22 <= m[8];
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_matrix(m);
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic elem_t rand_elem();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return elem_t'(16'h8000);
    if (p == 1) return elem_t'(16'h7fff);
    if (p < 5) return elem_t'($urandom_range(0, 32767) - 16384);
    return elem_t'($urandom);
  endfunction

  // A signed axis permutation, not always a proper rotation, perturbed slightly.
  task automatic make_rotation(output elem_t m[9]);
    int perm[3], sgn[3], t, j;
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    for (int i = 0; i < 3; i++) sgn[i] = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < 9; i++) m[i] = elem_t'($urandom_range(0, 2000) - 1000);
    for (int i = 0; i < 3; i++)
      m[3 * i + perm[i]] = elem_t'(sgn[i] * ((1 << FB) - $urandom_range(0, 3000)));
  endtask

  initial begin
    elem_t m[9];
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: identity, the three half turns, all zeros, extremes, other corner cases.
    m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_matrix(m);
    m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_matrix(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(m);
    m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_matrix(m);
    m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_matrix(m);
    m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768}; send_matrix(m);
    m = '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 1}; send_matrix(m);
    m = '{-20000, 0, 0, 0, -20000, 0, 0, 0, 3000}; send_matrix(m);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, -2}; send_matrix(m);
    m = '{0, 5, 7, -5, 0, 9, -7, -9, 0}; send_matrix(m);
    m = '{100, 0, 0, 0, 100, 0, 0, 0, -200}; send_matrix(m);
    m = '{-100, 32767, -32768, -32768, -100, 32767, 32767, -32768, -100}; send_matrix(m);
    m = '{0, 0, 0, 0, 5, 0, 0, 0, 5}; send_matrix(m);
    for (int n = 0; n < 935; n++) begin
      if ($urandom_range(0, 9) < 7) make_rotation(m);
      else for (int i = 0; i < 9; i++) m[i] = rand_elem();
      send_matrix(m);
      if (n == 400) long_hold <= 1;
      pause_input((long_hold && !hold_done) ? 0 : gap_len());
    end
    in_valid <= 0;
    feeding_done <= 1;
  end

  // Output side: random stalls, plus one long hold while the input keeps going.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (long_hold && !hold_done) begin
        out_stall <= 1;
        repeat (120) @(posedge clk);
        hold_done <= 1;
      end
      n = gap_len();
      out_stall <= (n > 0);
      repeat (n > 0 ? n : $urandom_range(1, 8)) @(posedge clk);
      out_stall <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_quat('{qw, qx, qy, qz, case_taken, degenerate});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    wait (feeding_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/rmq_pkg.sv
rtl/rmq_div_lane.sv
rtl/rotation_matrix_to_quaternion_unit.sv
verif/tb.sv
